@@ rtl/skcg_pkg.sv @@
// skcg_pkg: widths, register indexes, reset values and shared types
// of the soft knee compressor gain computer
// no dependencies; used by skcg_div and soft_knee_compressor_gain
package skcg_pkg;

  // field and register widths
  localparam int LVL_W = 16;
  localparam int T_W   = 15;
  localparam int R_W   = 15;
  localparam int K_W   = 13;
  localparam int M_W   = 14;
  localparam int RED_W = 15;
  localparam int CFG_W = 15;
  localparam int IDX_W = 3;

  // datapath widths
  localparam int C_W   = LVL_W + 2;   // curve value and overshoot
  localparam int TW_W  = LVL_W + 3;   // twice the overshoot
  localparam int D_W   = 14;          // knee distance, 0..2*knee
  localparam int SUM_W = RED_W + 4;   // 7*avg + 3*gr
  localparam int MA_W  = 16;
  localparam int MB_W  = 28;
  localparam int NUM_W = MA_W + MB_W; // dividend and product
  localparam int DEN_W = 31;
  localparam int QUO_W = 16;
  localparam int DSH_W = DEN_W + QUO_W - 1;
  localparam int CNT_W = $clog2(QUO_W);

  // legal ranges and reset values
  localparam logic signed [T_W-1:0] T_MIN   = -15'sd15360;
  localparam logic signed [T_W-1:0] T_RESET = -15'sd4608;
  localparam logic [R_W-1:0] R_MIN   = 15'd256;
  localparam logic [R_W-1:0] R_MAX   = 15'd25600;
  localparam logic [R_W-1:0] R_RESET = 15'd896;
  localparam logic [K_W-1:0] K_MAX   = 13'd6144;
  localparam logic [K_W-1:0] K_RESET = 13'd1536;
  localparam int OUT_MAX = 32767;
  localparam int OUT_MIN = -32768;
  localparam int RED_MAX = 32767;

  // divide by ten as (x/2) * ceil(2^18/5) >> 18, exact for x/2 below 2^18
  localparam logic [MA_W-1:0] AVG_RECIP = 16'd52429;
  localparam int              AVG_SH    = 18;

  // configuration register indexes
  localparam logic [IDX_W-1:0] REG_THRESHOLD = 3'd0;
  localparam logic [IDX_W-1:0] REG_RATIO     = 3'd1;
  localparam logic [IDX_W-1:0] REG_KNEE      = 3'd2;
  localparam logic [IDX_W-1:0] REG_MAKEUP    = 3'd3;
  localparam logic [IDX_W-1:0] REG_ENABLE    = 3'd4;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLASS,
    S_SCALE,
    S_DEN,
    S_KDIV,
    S_DIV,
    S_FIN,
    S_AVG,
    S_AVGW,
    S_DONE
  } state_t;

  typedef enum logic {
    PATH_COMP,
    PATH_KNEE
  } path_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [QUO_W-1:0] quo;
  } div_rsp_t;

endpackage

@@ rtl/skcg_div.sv @@
// skcg_div: restoring divider, one quotient bit per cycle
// depends on skcg_pkg for widths and the request/response structs
module skcg_div import skcg_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [NUM_W-1:0] rem;
  logic [DSH_W-1:0] dsh;
  logic [QUO_W-1:0] quo;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;
  logic             ge;

  assign ge = DSH_W'(rem) >= dsh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == '0);
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && (cnt == '0)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= req.num;
      dsh <= {req.den, {(QUO_W-1){1'b0}}};
      quo <= '0;
      cnt <= CNT_W'(QUO_W - 1);
    end else if (busy) begin
      if (ge) begin
        rem <= rem - dsh[NUM_W-1:0];
      end
      quo <= {quo[QUO_W-2:0], ge};
      dsh <= dsh >> 1;
      cnt <= cnt - 1'b1;
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.quo  = quo;

endmodule

@@ rtl/soft_knee_compressor_gain.sv @@
// soft_knee_compressor_gain: static gain computer of a dynamics compressor
// depends on skcg_pkg and skcg_div
//
// Each input beat carries one level in dB (signed Q8.8) and produces one output
// beat: the curve output plus makeup (saturated to 16 bits), the instantaneous
// gain reduction and a one-pole smoothed reduction (0.7 old, 0.3 new) for
// metering. Below threshold - knee/2 the curve is the identity, above
// threshold + knee/2 the overshoot is divided by the ratio, and in between a
// quadratic soft knee joins the two; a knee of zero gives a hard knee.
// Threshold, ratio and knee are clamped to their legal ranges before use.
// Configuration is a plain write port (threshold, ratio, knee, makeup, enable
// at indexes 0 to 4) and is meant to be written only while no beat is in
// flight. Items are handled one at a time by a small sequencer around one
// shared multiplier and one 16-step restoring divider. The identity part of
// the curve needs no divider pass; the compressed part and the knee each run
// one divider pass for the curve, the knee after the scale and denominator
// states, while the smoothing divide by ten is a reciprocal multiply on the
// shared multiplier. A new level is accepted only once the previous result
// has been loaded into the output register. A finished result sits in an
// output register, so the next level is accepted while the previous result
// waits for the consumer.
module soft_knee_compressor_gain import skcg_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  // configuration write port
  input  logic                    cfg_write,
  input  logic [IDX_W-1:0]        cfg_index,
  input  logic [CFG_W-1:0]        cfg_data,
  // input beats
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [LVL_W-1:0] level_db,
  // output beats
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [LVL_W-1:0] out_db,
  output logic [RED_W-1:0]        reduction_db,
  output logic [RED_W-1:0]        smoothed_reduction_db
);

  // configuration registers
  logic signed [T_W-1:0] threshold_db;
  logic [R_W-1:0]        ratio;
  logic [K_W-1:0]        knee_db;
  logic signed [M_W-1:0] makeup_db;
  logic                  enable;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold_db <= T_RESET;
      ratio        <= R_RESET;
      knee_db      <= K_RESET;
      makeup_db    <= '0;
      enable       <= 1'b1;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_THRESHOLD: threshold_db <= cfg_data[T_W-1:0];
        REG_RATIO:     ratio        <= cfg_data[R_W-1:0];
        REG_KNEE:      knee_db      <= cfg_data[K_W-1:0];
        REG_MAKEUP:    makeup_db    <= cfg_data[M_W-1:0];
        REG_ENABLE:    enable       <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // clamp to legal ranges; the user keeps them stable while an item is in flight, the block does not enforce it
  logic signed [T_W-1:0] t_c;
  logic [R_W-1:0]        r_c;
  logic [K_W-1:0]        k_c;

  always_comb begin
    if (threshold_db > 0) begin
      t_c = '0;
    end else if (threshold_db < T_MIN) begin
      t_c = T_MIN;
    end else begin
      t_c = threshold_db;
    end
    if (ratio < R_MIN) begin
      r_c = R_MIN;
    end else if (ratio > R_MAX) begin
      r_c = R_MAX;
    end else begin
      r_c = ratio;
    end
    if (knee_db > K_MAX) begin
      k_c = K_MAX;
    end else begin
      k_c = knee_db;
    end
  end

  // sequencer and datapath registers
  state_t                state, state_next;
  path_t                 path;
  logic signed [LVL_W-1:0] lvl;
  logic signed [C_W-1:0] c;
  logic [NUM_W-1:0]      num_r;
  logic [NUM_W-1:0]      prod;
  logic signed [LVL_W-1:0] o_r;
  logic [RED_W-1:0]      gr_r;
  logic [RED_W-1:0]      avg;

  // overshoot and curve region
  logic signed [C_W-1:0]  over;
  logic signed [TW_W-1:0] twice;
  logic signed [TW_W-1:0] k_s;
  logic signed [TW_W-1:0] d_full;
  logic [D_W-1:0]         d;
  logic                   is_ident;
  logic                   is_comp;

  assign over   = C_W'(lvl) - C_W'(t_c);
  assign twice  = {over, 1'b0};
  assign k_s    = {{(TW_W-K_W){1'b0}}, k_c};
  assign d_full = twice + k_s;
  assign d      = d_full[D_W-1:0];

  always_comb begin
    if (k_c == '0) begin
      is_ident = (over <= 0);
    end else begin
      is_ident = (twice < -k_s);
    end
    is_comp = (twice > k_s);
  end

  // dividend and divisor for each divider pass, and the smoothing sum
  logic [NUM_W-1:0] comp_num;
  logic [NUM_W-1:0] knee_num;
  logic [DEN_W-1:0] knee_den;
  logic [SUM_W-1:0] avg_num;

  // over*256 + ratio/2, rounding to nearest
  assign comp_num = (NUM_W'(over[C_W-2:0]) << 8) + NUM_W'(r_c >> 1);
  // den = 8*k*r, plus den/2 for rounding
  assign knee_den = {prod[MB_W-1:0], 3'b000};
  assign knee_num = num_r + NUM_W'({prod[MB_W-1:0], 2'b00});
  // 7*avg + 3*gr
  assign avg_num  = (SUM_W'(avg) << 3) - SUM_W'(avg)
                  + (SUM_W'(gr_r) << 1) + SUM_W'(gr_r);

  // shared multiplier: d*d, then (r-1.0)*d*d, then k*r, and the
  // reciprocal of five for the smoothing divide
  logic [MA_W-1:0]  mul_a;
  logic [MB_W-1:0]  mul_b;
  logic [NUM_W-1:0] mul_p;

  always_comb begin
    case (state)
      S_CLASS: begin
        mul_a = MA_W'(d);
        mul_b = MB_W'(d);
      end
      S_SCALE: begin
        mul_a = MA_W'(r_c - R_MIN);
        mul_b = prod[MB_W-1:0];
      end
      S_AVG: begin
        mul_a = AVG_RECIP;
        mul_b = MB_W'(avg_num >> 1);
      end
      default: begin
        mul_a = MA_W'(r_c);
        mul_b = MB_W'(k_c);
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  always_ff @(posedge clk) begin
    prod <= mul_p;
  end

  div_req_t div_req;
  div_rsp_t div_rsp;

  skcg_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // next state and divider requests
  always_comb begin
    state_next    = state;
    div_req.start = 1'b0;
    div_req.num   = '0;
    div_req.den   = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_CLASS;
        end
      end
      S_CLASS: begin
        if (is_ident) begin
          state_next = S_FIN;
        end else if (is_comp) begin
          div_req.start = 1'b1;
          div_req.num   = comp_num;
          div_req.den   = DEN_W'(r_c);
          state_next    = S_DIV;
        end else begin
          state_next = S_SCALE;
        end
      end
      S_SCALE: state_next = S_DEN;
      S_DEN:   state_next = S_KDIV;
      S_KDIV: begin
        div_req.start = 1'b1;
        div_req.num   = knee_num;
        div_req.den   = knee_den;
        state_next    = S_DIV;
      end
      S_DIV: begin
        if (div_rsp.done) begin
          state_next = S_FIN;
        end
      end
      S_FIN:  state_next = S_AVG;
      S_AVG:  state_next = S_AVGW;
      S_AVGW: state_next = S_DONE;
      S_DONE: begin
        if (!out_valid || out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  // curve output, makeup and reduction
  logic signed [C_W:0] out_sum;
  logic signed [C_W:0] gr_full;
  logic signed [C_W-1:0] quo_s;

  assign quo_s   = $signed(C_W'(div_rsp.quo));
  assign out_sum = (C_W+1)'(c) + (C_W+1)'(makeup_db);
  assign gr_full = (C_W+1)'(lvl) - (C_W+1)'(c);

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          lvl <= level_db;
        end
      end
      S_CLASS: begin
        c    <= C_W'(lvl);
        path <= is_comp ? PATH_COMP : PATH_KNEE;
      end
      S_DEN: num_r <= prod;
      S_DIV: begin
        if (div_rsp.done) begin
          if (path == PATH_COMP) begin
            c <= C_W'(t_c) + quo_s;
          end else begin
            c <= C_W'(lvl) - quo_s;
          end
        end
      end
      S_FIN: begin
        if (out_sum > OUT_MAX) begin
          o_r <= LVL_W'(OUT_MAX);
        end else if (out_sum < OUT_MIN) begin
          o_r <= LVL_W'(OUT_MIN);
        end else begin
          o_r <= out_sum[LVL_W-1:0];
        end
        // reduction is input minus curve, before makeup
        if (!enable || (gr_full < 0)) begin
          gr_r <= '0;
        end else if (gr_full > RED_MAX) begin
          gr_r <= RED_W'(RED_MAX);
        end else begin
          gr_r <= gr_full[RED_W-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  // smoothed reduction, floor((7*avg + 3*gr) / 10), never above 32767
  always_ff @(posedge clk) begin
    if (rst) begin
      avg <= '0;
    end else if (state == S_AVGW) begin
      avg <= prod[AVG_SH+RED_W-1:AVG_SH];
    end
  end

  // output register, frees the sequencer while a beat waits
  logic out_load;
  assign out_load = (state == S_DONE) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_db                <= o_r;
      reduction_db          <= gr_r;
      smoothed_reduction_db <= avg;
    end
  end

  // checks
  a_div_start_idle: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  a_div_done_expected: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == S_DIV))
    else $error("divider result with no pass waiting for it");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second level accepted while one is in work");

  a_disabled_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !enable) |-> (reduction_db == '0))
    else $error("reduction reported while disabled");

endmodule
